// ===== design/lcd_rect_fill_byte_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// lcd rect fill byte sequencer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef LCD_RECT_FILL_BYTE_SEQUENCER_DEFINES_SVH
`define LCD_RECT_FILL_BYTE_SEQUENCER_DEFINES_SVH

// condition must hold at every edge out of reset
`define LRF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define LRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define LRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/lrf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrf_pkg
// shared types, codes and helpers for the lcd rectangle fill sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrf_pkg;

  // default panel geometry
  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 128;

  // panel commands
  localparam logic [7:0] CMD_COL_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_BUSY   = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  // sequencer phases
  localparam logic [3:0] PH_COL_CMD  = 4'd0;
  localparam logic [3:0] PH_COL_S_HI = 4'd1;
  localparam logic [3:0] PH_COL_S_LO = 4'd2;
  localparam logic [3:0] PH_COL_E_HI = 4'd3;
  localparam logic [3:0] PH_COL_E_LO = 4'd4;
  localparam logic [3:0] PH_ROW_CMD  = 4'd5;
  localparam logic [3:0] PH_ROW_S_HI = 4'd6;
  localparam logic [3:0] PH_ROW_S_LO = 4'd7;
  localparam logic [3:0] PH_ROW_E_HI = 4'd8;
  localparam logic [3:0] PH_ROW_E_LO = 4'd9;
  localparam logic [3:0] PH_MEM_CMD  = 4'd10;
  localparam logic [3:0] PH_PIXELS   = 4'd11;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_READY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 2'd2;

  localparam logic [6:0] COLUMN_OFFSET_RST = 7'd2;
  localparam logic [6:0] ROW_OFFSET_RST    = 7'd3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rect_x;
    logic [7:0]  rect_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [15:0] fill_color;
  } item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic       display_ready;
    logic [6:0] column_offset;
    logic [6:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic        busy;
    logic [3:0]  phase;
    logic [7:0]  win_col_start;
    logic [7:0]  win_col_end;
    logic [7:0]  win_row_start;
    logic [7:0]  win_row_end;
    logic        low_half_next;
    logic [15:0] held_color;
  } seq_state_t;

  // byte k of the pair (a0 + off, a1 + off), high byte first
  function automatic logic [7:0] addr_byte(input logic [7:0] a0, input logic [7:0] a1,
                                           input logic [6:0] off, input logic [1:0] k);
    logic [8:0] v;
    v = (k[1] ? {1'b0, a1} : {1'b0, a0}) + {2'b00, off};
    return k[0] ? v[7:0] : {7'd0, v[8]};
  endfunction

endpackage

// ===== design/lrf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lrf_cfg_regs
// configuration register file: display ready flag and address offsets
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrf_cfg_regs
  import lrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_ready <= 1'b0;
      cfg.column_offset <= COLUMN_OFFSET_RST;
      cfg.row_offset    <= ROW_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DISPLAY_READY: cfg.display_ready <= cfg_data[0];
        CFG_COLUMN_OFFSET: cfg.column_offset <= cfg_data;
        CFG_ROW_OFFSET:    cfg.row_offset    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/lrf_step.sv =====
// ----------------------------------------------------------------------------
// lrf_step
// next state and result word for one accepted item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrf_step
  import lrf_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int PIX_W        = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1)
)(
  input  item_t             item,
  input  cfg_t              cfg,
  input  seq_state_t        state,
  input  logic [PIX_W-1:0]  pixels_left,
  output seq_state_t        state_next,
  output logic [PIX_W-1:0]  pixels_left_next,
  output result_t           result
);

  localparam logic [8:0] PW9 = 9'(PANEL_WIDTH);
  localparam logic [8:0] PH9 = 9'(PANEL_HEIGHT);

  logic             reject;
  logic [8:0]       sum_x;
  logic [8:0]       sum_y;
  logic [7:0]       w_clip;
  logic [7:0]       h_clip;
  logic [15:0]      area;
  logic [PIX_W-1:0] pix_dec;

  // start request checks and clipping
  assign reject = !cfg.display_ready || (item.rect_width == 8'd0) ||
                  (item.rect_height == 8'd0) ||
                  ({1'b0, item.rect_x} >= PW9) || ({1'b0, item.rect_y} >= PH9);
  assign sum_x  = {1'b0, item.rect_x} + {1'b0, item.rect_width};
  assign sum_y  = {1'b0, item.rect_y} + {1'b0, item.rect_height};
  assign w_clip = (sum_x > PW9) ? 8'(PW9 - {1'b0, item.rect_x}) : item.rect_width;
  assign h_clip = (sum_y > PH9) ? 8'(PH9 - {1'b0, item.rect_y}) : item.rect_height;
  assign area   = w_clip * h_clip;
  assign pix_dec = pixels_left - PIX_W'(1);

  always_comb begin
    state_next       = state;
    pixels_left_next = pixels_left;
    result           = '0;
    if (item.kind == KIND_START) begin
      if (state.busy) begin
        result.status = ST_BUSY;
      end else if (reject) begin
        result.status = ST_REJECT;
      end else begin
        state_next.win_col_start = item.rect_x;
        state_next.win_col_end   = 8'({1'b0, item.rect_x} + {1'b0, w_clip} - 9'd1);
        state_next.win_row_start = item.rect_y;
        state_next.win_row_end   = 8'({1'b0, item.rect_y} + {1'b0, h_clip} - 9'd1);
        state_next.held_color    = item.fill_color;
        state_next.low_half_next = 1'b0;
        state_next.phase         = PH_COL_CMD;
        state_next.busy          = 1'b1;
        pixels_left_next         = PIX_W'(area);
        result.status            = ST_OK;
      end
    end else if (!state.busy) begin
      result.status = ST_IDLE;
    end else begin
      result.status   = ST_OK;
      result.has_byte = 1'b1;
      result.is_data  = 1'b1;
      state_next.phase = 4'(state.phase + 4'd1);
      unique case (state.phase) inside
        PH_COL_CMD: begin
          result.out_byte = CMD_COL_SET;
          result.is_data  = 1'b0;
        end
        PH_COL_S_HI, PH_COL_S_LO, PH_COL_E_HI, PH_COL_E_LO: begin
          result.out_byte = addr_byte(state.win_col_start, state.win_col_end,
                                      cfg.column_offset, 2'(state.phase - PH_COL_S_HI));
        end
        PH_ROW_CMD: begin
          result.out_byte = CMD_ROW_SET;
          result.is_data  = 1'b0;
        end
        PH_ROW_S_HI, PH_ROW_S_LO, PH_ROW_E_HI, PH_ROW_E_LO: begin
          result.out_byte = addr_byte(state.win_row_start, state.win_row_end,
                                      cfg.row_offset, 2'(state.phase - PH_ROW_S_HI));
        end
        PH_MEM_CMD: begin
          result.out_byte = CMD_MEM_WRITE;
          result.is_data  = 1'b0;
        end
        PH_PIXELS: begin
          state_next.phase = PH_PIXELS;
          if (!state.low_half_next) begin
            result.out_byte          = state.held_color[15:8];
            state_next.low_half_next = 1'b1;
          end else begin
            result.out_byte          = state.held_color[7:0];
            state_next.low_half_next = 1'b0;
            pixels_left_next         = pix_dec;
            result.last              = (pix_dec == '0);
            if (pix_dec == '0) begin
              state_next.busy  = 1'b0;
              state_next.phase = PH_COL_CMD;
            end
          end
        end
        default: begin
          result = '0;
          state_next.phase = state.phase;
        end
      endcase
    end
  end

endmodule

// ===== design/lcd_rect_fill_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_rect_fill_byte_sequencer
// the result word of an accepted item is registered in the output register
// throughput: one item per cycle while the result side is ready, the output register being the only stage
// the output register frees as it is read, so a new item enters while a result is taken
// reset: synchronous active high, clears the sequencer state and the result valid flag
// config resets to display not ready, column offset 2, row offset 3
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_rect_fill_byte_sequencer_defines.svh"

module lcd_rect_fill_byte_sequencer
  import lrf_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // item channel: start requests and byte ticks
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  // result channel
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result
);

  // pixel counter sized for a full panel
  localparam int PIX_W = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);

  cfg_t             cfg;
  seq_state_t       state;
  seq_state_t       state_next;
  logic [PIX_W-1:0] pixels_left;
  logic [PIX_W-1:0] pixels_left_next;
  result_t          result_next;
  logic             item_accept;

  // configuration registers
  lrf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // per-item logic: checks, clipping, phase advance, byte select
  lrf_step #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .PIX_W        (PIX_W)
  ) u_step (
    .item             (item),
    .cfg              (cfg),
    .state            (state),
    .pixels_left      (pixels_left),
    .state_next       (state_next),
    .pixels_left_next (pixels_left_next),
    .result           (result_next)
  );

  // take a word whenever the output register is empty or being drained
  assign item_ready  = !result_valid || result_ready;
  assign item_accept = item_valid && item_ready;

  // sequencer state, updated once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      pixels_left <= '0;
    end else if (item_accept) begin
      state       <= state_next;
      pixels_left <= pixels_left_next;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // output register payload, no reset needed
  always_ff @(posedge clk) begin
    if (item_accept) begin
      result <= result_next;
    end
  end

  // idle sequencer always sits at the column command
  `LRF_ASSERT_ALWAYS(a_idle_phase, state.busy || (state.phase == PH_COL_CMD), "idle with phase set")
  // phase never runs past the pixel phase
  `LRF_ASSERT_ALWAYS(a_phase_range, state.phase <= PH_PIXELS, "phase out of range")
  // pixel streaming always has pixels left to send
  `LRF_ASSERT_SAME(a_pix_left, state.busy && (state.phase == PH_PIXELS), pixels_left != '0, "pixel phase with zero count")
  // the last byte ends the fill
  `LRF_ASSERT_NEXT(a_last_idle, item_accept && result_next.last, !state.busy, "busy after last byte")
  // bytes only carry ok status
  `LRF_ASSERT_SAME(a_byte_ok, result_valid && result.has_byte, result.status == ST_OK, "byte with bad status")

endmodule
